// ===== rtl/core/psn_pkg.sv =====
// ----------------------------------------------------------------------------
// psn_pkg
// Shared types and character codes for the path string normalizer.
// ----------------------------------------------------------------------------
package psn_pkg;

    // character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // most results one input beat can produce
    localparam int unsigned MAX_RESULTS = 2;
    localparam int unsigned CNT_W       = 2;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_path;
    } t_result;

    // results of one input beat
    typedef struct packed {
        logic [CNT_W-1:0] count;
        t_result          res1;
        t_result          res0;
    } t_result_pair;

endpackage

// ===== rtl/core/path_string_normalizer_unit.sv =====
// ----------------------------------------------------------------------------
// path_string_normalizer_unit
// Streaming path normalizer: one path byte per beat in, normalized bytes out.
// ----------------------------------------------------------------------------
// channel   | direction | signals                          | contents
// s_axis    | in        | s_axis_tvalid/tready/tdata/tlast | raw byte, last byte
// m_axis    | out       | m_axis_tvalid/tready/tdata/tuser/tlast | byte, has_byte, end
// cfg       | in        | i_cfg_valid, o_cfg_ready, i_cfg_data | fold_case
//
// An input beat is decided in the cycle it is accepted; its results queue
// behind earlier ones and leave on m_axis one beat per cycle while
// m_axis_tready is high. Input takes one beat per cycle while there is room;
// a two-result beat needs an extra output beat from the queue's single port.
// Input is taken while the result queue holds at most one entry.
// Synchronous active-low reset empties the queue, clears fold_case and
// starts a fresh string.
// ----------------------------------------------------------------------------
module path_string_normalizer_unit
    import psn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,      // [0] fold_case
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic       s_axis_tlast,    // is_last
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tuser,    // [0] has_byte
    output logic       m_axis_tlast     // end_of_path
);

    t_result_pair pair;
    t_result      head;
    logic         room;
    logic         in_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && room;

    // rule logic and string state
    psn_rules u_rules (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_fold (i_cfg_data),
        .i_accept   (in_accept),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .o_pair     (pair)
    );

    // result queue
    psn_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_pair  (pair),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .i_pop   (m_axis_tready)
    );

    assign m_axis_tdata = head.out_byte;
    assign m_axis_tuser = head.has_byte;
    assign m_axis_tlast = head.end_of_path;

endmodule

// ===== rtl/core/psn_rules.sv =====
// ----------------------------------------------------------------------------
// psn_rules
// Per-byte rule logic: slash mapping and collapse, case fold, leading "./"
// strip and trailing slash drop. Holds the string state and fold register.
// ----------------------------------------------------------------------------
module psn_rules
    import psn_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_fold,
    input  logic         i_accept,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_result_pair o_pair
);

    logic r_fold_case;
    logic r_prev_slash, r_in_prefix, r_dot_held, r_slash_held;
    logic n_prev_slash, n_in_prefix, n_dot_held, n_slash_held;

    logic [7:0]       c_map;
    logic [7:0]       c_fold;
    logic             is_slash;
    logic [CNT_W-1:0] cnt;
    t_result          res0, res1;

    // fold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case <= 1'b0;
        end else if (i_cfg_we) begin
            r_fold_case <= i_cfg_fold;
        end
    end

    // byte mapping
    always_comb begin
        c_map    = (i_byte == CH_BACKSLASH) ? CH_SLASH : i_byte;
        is_slash = (c_map == CH_SLASH);
        c_fold   = c_map;
        if (r_fold_case && c_map >= CH_UPPER_A && c_map <= CH_UPPER_Z) begin
            c_fold = c_map + CASE_OFFSET;
        end
    end

    // rule decision and results
    always_comb begin
        n_prev_slash = r_prev_slash;
        n_in_prefix  = r_in_prefix;
        n_dot_held   = r_dot_held;
        n_slash_held = r_slash_held;
        cnt          = '0;
        res0         = '{out_byte: 8'h00, has_byte: 1'b0, end_of_path: 1'b0};
        res1         = '{out_byte: 8'h00, has_byte: 1'b0, end_of_path: 1'b0};

        if (is_slash) begin
            if (!r_prev_slash) begin
                n_prev_slash = 1'b1;
                if (r_in_prefix && r_dot_held) begin
                    // strip a leading "./"
                    n_dot_held = 1'b0;
                end else begin
                    n_in_prefix  = 1'b0;
                    n_slash_held = 1'b1;
                end
            end
        end else begin
            n_prev_slash = 1'b0;
            if (r_in_prefix) begin
                if (r_dot_held) begin
                    res0        = '{out_byte: CH_DOT, has_byte: 1'b1, end_of_path: 1'b0};
                    res1        = '{out_byte: c_fold, has_byte: 1'b1, end_of_path: 1'b0};
                    cnt         = 2'd2;
                    n_dot_held  = 1'b0;
                    n_in_prefix = 1'b0;
                end else if (c_fold == CH_DOT) begin
                    n_dot_held = 1'b1;
                end else begin
                    res0        = '{out_byte: c_fold, has_byte: 1'b1, end_of_path: 1'b0};
                    cnt         = 2'd1;
                    n_in_prefix = 1'b0;
                end
            end else if (r_slash_held) begin
                res0         = '{out_byte: CH_SLASH, has_byte: 1'b1, end_of_path: 1'b0};
                res1         = '{out_byte: c_fold, has_byte: 1'b1, end_of_path: 1'b0};
                cnt          = 2'd2;
                n_slash_held = 1'b0;
            end else begin
                res0 = '{out_byte: c_fold, has_byte: 1'b1, end_of_path: 1'b0};
                cnt  = 2'd1;
            end
        end

        // end of string: flush held dot, or give the empty marker
        if (i_last) begin
            if (n_dot_held) begin
                // no other result is possible while a dot is held
                res0 = '{out_byte: CH_DOT, has_byte: 1'b1, end_of_path: 1'b0};
                cnt  = 2'd1;
            end
            if (cnt == 2'd0) begin
                cnt = 2'd1;
            end
            if (cnt == 2'd2) begin
                res1.end_of_path = 1'b1;
            end else begin
                res0.end_of_path = 1'b1;
            end
            n_prev_slash = 1'b0;
            n_in_prefix  = 1'b1;
            n_dot_held   = 1'b0;
            n_slash_held = 1'b0;
        end

        o_pair = '{count: cnt, res1: res1, res0: res0};
    end

    // string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_slash <= 1'b0;
            r_in_prefix  <= 1'b1;
            r_dot_held   <= 1'b0;
            r_slash_held <= 1'b0;
        end else if (i_accept) begin
            r_prev_slash <= n_prev_slash;
            r_in_prefix  <= n_in_prefix;
            r_dot_held   <= n_dot_held;
            r_slash_held <= n_slash_held;
        end
    end

endmodule

// ===== rtl/core/psn_outq.sv =====
// ----------------------------------------------------------------------------
// psn_outq
// Three-entry result queue: takes up to two results per cycle, hands out
// one per cycle from the head entry while i_pop is high.
// ----------------------------------------------------------------------------
module psn_outq
    import psn_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_result_pair i_pair,
    output logic         o_room,
    output logic         o_valid,
    output t_result      o_head,
    input  logic         i_pop
);

    localparam int unsigned DEPTH = MAX_RESULTS + 1;

    t_result      r_q [DEPTH];
    t_result      n_q [DEPTH];
    logic [1:0]   r_count, n_count;
    logic [1:0]   base;
    logic [1:0]   push_cnt;
    logic         pop_now;

    assign pop_now  = i_pop && (r_count != 2'd0);
    assign push_cnt = i_push ? i_pair.count : 2'd0;
    assign base     = r_count - {1'b0, pop_now};
    assign o_room   = (r_count <= 2'd1);
    assign o_valid  = (r_count != 2'd0);
    assign o_head   = r_q[0];

    // shift on pop, then place new results
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (pop_now && i < DEPTH - 1) begin
                n_q[i] = r_q[i+1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push_cnt != 2'd0 && base == 2'(i)) begin
                n_q[i] = i_pair.res0;
            end
            if (push_cnt == 2'd2 && base + 2'd1 == 2'(i)) begin
                n_q[i] = i_pair.res1;
            end
        end
        n_count = base + push_cnt;
    end

    // payload entries
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/psn_checker.sv =====
// ----------------------------------------------------------------------------
// psn_checker
// Port-level checks for the path string normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module psn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled output beat stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // an empty marker always ends the path
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
        else $error("empty result without end flag or with data");

    // when no input was taken: output only drains what was accepted
    a_idle_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("output beat appeared without input");

    // no output in the cycle right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind path_string_normalizer_unit psn_checker u_psn_checker (.*);
